### src/ssd_pkg.sv
// Package for the section stream deframer: beat structs, codes and sizes.
// Used by every module under src; depends on nothing.
package ssd_pkg;

  localparam int ADDRESS_WIDTH = 29;
  localparam int SIZE_W        = 31;  // a size that passes its limit check fits here
  localparam int HEADER_BYTES  = 11;

  localparam logic [23:0] TAG_KEY = 24'h4B4559;  // "KEY"
  localparam logic [23:0] TAG_Z80 = 24'h5A3830;  // "Z80"
  localparam logic [23:0] TAG_SMP = 24'h534D50;  // "SMP"

  localparam logic [3:0]  KEY_LIMIT_RESET     = 4'd11;
  localparam logic [19:0] PROGRAM_LIMIT_RESET = 20'd524288;
  localparam logic [29:0] SAMPLE_LIMIT_RESET  = 30'd536870912;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FAILED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TGT_KEY     = 2'd0,
    TGT_PROGRAM = 2'd1,
    TGT_SAMPLE  = 2'd2
  } target_t;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_OK      = 2'd1,
    ST_FAILED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_KEY_LIMIT     = 2'd0,
    CFG_PROGRAM_LIMIT = 2'd1,
    CFG_SAMPLE_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic                     write_valid;
    logic [1:0]               target_store;
    logic [ADDRESS_WIDTH-1:0] write_address;
    logic [7:0]               write_data;
    logic [1:0]               load_status;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  key_limit;
    logic [19:0] program_limit;
    logic [29:0] sample_limit;
  } limits_t;

endpackage

### src/ssd_parser.sv
// Section parser: header assembly, limit check and payload address stepping.
// Depends on ssd_pkg.
module ssd_parser import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_beat_t  beat,
  input  limits_t   limits,
  output out_beat_t result
);

  phase_t                   phase, phase_next;
  logic [3:0]               header_count, header_count_next;
  logic [15:0]              tag_bytes;        // first two tag characters
  logic [7:0]               tag_last;         // third tag character
  logic [31:0]              section_offset;
  logic [23:0]              size_low;         // size bytes 0..2
  logic [SIZE_W-1:0]        remaining, remaining_next;
  logic [ADDRESS_WIDTH-1:0] address, address_next;
  target_t                  current_target, current_target_next;

  logic [31:0] size_full;
  logic [32:0] end_pos;
  logic        boundary;

  // At the last header byte the top size byte is still on the input.
  assign size_full = {beat.byte_in, size_low};
  assign end_pos   = {1'b0, size_full} + {1'b0, section_offset};

  logic tag_known_full;
  always_comb begin
    tag_known_full = 1'b1;
    unique case ({tag_bytes, tag_last})
      TAG_KEY, TAG_Z80, TAG_SMP: tag_known_full = 1'b1;
      default:                   tag_known_full = 1'b0;
    endcase
  end

  target_t sel_target;
  logic [29:0] sel_limit;
  always_comb begin
    sel_target = TGT_KEY;
    sel_limit  = {26'd0, limits.key_limit};
    unique case ({tag_bytes, tag_last})
      TAG_Z80: begin
        sel_target = TGT_PROGRAM;
        sel_limit  = {10'd0, limits.program_limit};
      end
      TAG_SMP: begin
        sel_target = TGT_SAMPLE;
        sel_limit  = limits.sample_limit;
      end
      default: begin
        sel_target = TGT_KEY;
        sel_limit  = {26'd0, limits.key_limit};
      end
    endcase
  end

  logic check_bad;
  assign check_bad = !tag_known_full || ({1'b0, section_offset} > {3'b0, sel_limit}) ||
                     (end_pos > {3'b0, sel_limit});

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    remaining_next      = remaining;
    address_next        = address;
    current_target_next = current_target;
    boundary            = 1'b0;
    result              = '0;
    unique case (phase)
      PH_HEADER: begin
        header_count_next = header_count + 4'd1;
        if (header_count == 4'(HEADER_BYTES - 1)) begin
          header_count_next   = '0;
          current_target_next = sel_target;
          address_next        = section_offset[ADDRESS_WIDTH-1:0];
          remaining_next      = size_full[SIZE_W-1:0];
          if (check_bad) begin
            phase_next = PH_FAILED;
          end else if (size_full == '0) begin
            boundary = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result.write_valid   = 1'b1;
        result.target_store  = current_target;
        result.write_address = address;
        result.write_data    = beat.byte_in;
        address_next         = address + ADDRESS_WIDTH'(1);
        remaining_next       = remaining - SIZE_W'(1);
        if (remaining == SIZE_W'(1)) begin
          phase_next = PH_HEADER;
          boundary   = 1'b1;
        end
      end
      default: begin
        phase_next = PH_FAILED;
      end
    endcase
    if (beat.end_of_stream) begin
      result.load_status = boundary ? ST_OK : ST_FAILED;
      phase_next         = PH_HEADER;
      header_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
    end else if (push) begin
      phase        <= phase_next;
      header_count <= header_count_next;
    end
  end

  // Header byte lanes: every lane is rewritten before it is used, so no clear.
  always_ff @(posedge clk) begin
    if (push) begin
      remaining      <= remaining_next;
      address        <= address_next;
      current_target <= current_target_next;
      if (phase == PH_HEADER) begin
        unique case (header_count)
          4'd0:    tag_bytes[15:8]       <= beat.byte_in;
          4'd1:    tag_bytes[7:0]        <= beat.byte_in;
          4'd2:    tag_last              <= beat.byte_in;
          4'd3:    section_offset[7:0]   <= beat.byte_in;
          4'd4:    section_offset[15:8]  <= beat.byte_in;
          4'd5:    section_offset[23:16] <= beat.byte_in;
          4'd6:    section_offset[31:24] <= beat.byte_in;
          4'd7:    size_low[7:0]         <= beat.byte_in;
          4'd8:    size_low[15:8]        <= beat.byte_in;
          4'd9:    size_low[23:16]       <= beat.byte_in;
          default: ;
        endcase
      end
    end
  end

endmodule

### src/ssd_out_buf.sv
// Two-entry output stage: result register plus a skid entry.
// Depends on ssd_pkg.
module ssd_out_buf import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_beat_t push_beat,
  output logic      full,
  output logic      result_valid,
  input  logic      result_stall,
  output out_beat_t result_beat
);

  logic      skid_valid;
  out_beat_t skid_beat;
  logic      pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      result_valid <= skid_valid || push;
      skid_valid   <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || pop) begin
      result_beat <= skid_valid ? skid_beat : push_beat;
    end else if (push) begin
      skid_beat <= push_beat;
    end
  end

endmodule

### src/section_stream_deframer.sv
// Top level of the section stream deframer: configuration registers,
// section parser and output stage. Depends on ssd_pkg, ssd_parser, ssd_out_buf.
//
// Takes one stream byte per beat and gives one result beat per byte, at a
// sustained rate of one byte per clock while the output is not stalled. Each
// accepted byte updates the parser state in the cycle it is taken; its result
// is registered in a two-entry output stage. byte_stall rises only when both
// output entries are held. Headers are 11 bytes (tag, LE offset, LE size);
// payload bytes come out as writes with write_valid set and the address
// offset + index wrapped to ADDRESS_WIDTH bits. Failures (unknown tag, offset
// or end beyond the store's limit) are sticky until the end-of-stream byte,
// which reports load_status ok or failed and restarts parsing. Writes issued
// before a failure are not retracted; discard them when the status is failed.
// Limit registers take writes at any time (cfg_ready is always high) but
// should only be changed while the block is idle. Index 3 is ignored.
module section_stream_deframer import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // stream bytes in
  input  logic        byte_valid,
  output logic        byte_stall,
  input  in_beat_t    byte_beat,
  // results out
  output logic        result_valid,
  input  logic        result_stall,
  output out_beat_t   result_beat,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);

  limits_t   limits;
  logic      full;
  logic      push;
  out_beat_t step_result;

  assign cfg_ready  = 1'b1;
  assign byte_stall = full;
  assign push       = byte_valid && !full;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.key_limit     <= KEY_LIMIT_RESET;
      limits.program_limit <= PROGRAM_LIMIT_RESET;
      limits.sample_limit  <= SAMPLE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_KEY_LIMIT:     limits.key_limit     <= cfg_data[3:0];
        CFG_PROGRAM_LIMIT: limits.program_limit <= cfg_data[19:0];
        CFG_SAMPLE_LIMIT:  limits.sample_limit  <= cfg_data;
        default:           ;
      endcase
    end
  end

  ssd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .beat   (byte_beat),
    .limits (limits),
    .result (step_result)
  );

  ssd_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_beat    (step_result),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

endmodule

### test/tb_top.sv
// Testbench for section_stream_deframer: random and directed section streams,
// checked beat by beat against a predictor kept inside this file.
// Depends on ssd_pkg and the RTL under src.
module tb_top;
  import ssd_pkg::*;

  localparam int HOLD_CYCLES     = 48;    // long receiver hold-off
  localparam int WATCHDOG_CYCLES = 1000;  // cycles with no beat on any channel

  typedef logic [7:0] octet_q_t[$];

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  in_beat_t    byte_beat;
  logic        result_valid;
  logic        result_stall;
  out_beat_t   result_beat;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;

  section_stream_deframer i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_beat    (byte_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the parser state and the limit registers
  phase_t      sh_phase;
  int          sh_count;
  logic [23:0] sh_tag;
  logic [31:0] sh_offset;
  logic [31:0] sh_size;
  logic [31:0] sh_index;
  target_t     sh_target;
  logic [3:0]  sh_key_limit;
  logic [19:0] sh_program_limit;
  logic [29:0] sh_sample_limit;

  out_beat_t predicted_results[$];
  int        mismatches   = 0;
  int        bytes_sent   = 0;
  int        rx_wait      = 0;
  int        stuck_cycles = 0;
  logic      no_gaps      = 1'b0;  // both sides run without idling
  logic      hold_req     = 1'b0;  // asks the receiver for a long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_section_state();
    sh_phase  = PH_HEADER;
    sh_count  = 0;
    sh_tag    = '0;
    sh_offset = '0;
    sh_size   = '0;
    sh_index  = '0;
    sh_target = TGT_KEY;
  endfunction

  // Advance the shadow parser by one byte and return the result beat it gives.
  function automatic out_beat_t deframe_byte(in_beat_t ib);
    out_beat_t   ob;
    logic        boundary;
    logic        tag_ok;
    logic [63:0] lim;
    logic [31:0] b32;
    logic [31:0] addr;
    ob       = '0;
    boundary = 1'b0;
    tag_ok   = 1'b1;
    lim      = '0;
    b32      = {24'd0, ib.byte_in};
    case (sh_phase)
      PH_HEADER: begin
        if (sh_count == 0) begin
          sh_tag    = '0;
          sh_offset = '0;
          sh_size   = '0;
        end
        if (sh_count < 3) sh_tag = {sh_tag[15:0], ib.byte_in};
        else if (sh_count < 7) sh_offset = sh_offset | (b32 << (8 * (sh_count - 3)));
        else sh_size = sh_size | (b32 << (8 * (sh_count - 7)));
        sh_count++;
        if (sh_count >= HEADER_BYTES) begin
          sh_count = 0;
          case (sh_tag)
            TAG_KEY: begin
              sh_target = TGT_KEY;
              lim = 64'(sh_key_limit);
            end
            TAG_Z80: begin
              sh_target = TGT_PROGRAM;
              lim = 64'(sh_program_limit);
            end
            TAG_SMP: begin
              sh_target = TGT_SAMPLE;
              lim = 64'(sh_sample_limit);
            end
            default: tag_ok = 1'b0;
          endcase
          // 64-bit compare so offset and size near 2^32 cannot wrap past the limit
          if (!tag_ok || 64'(sh_offset) > lim || 64'(sh_size) > lim - 64'(sh_offset)) begin
            sh_phase = PH_FAILED;
          end else begin
            sh_index = '0;
            sh_phase = (sh_size == 0) ? PH_HEADER : PH_PAYLOAD;
          end
          boundary = (sh_phase == PH_HEADER);
        end
      end
      PH_PAYLOAD: begin
        addr             = sh_offset + sh_index;
        ob.write_valid   = 1'b1;
        ob.target_store  = sh_target;
        ob.write_address = addr[ADDRESS_WIDTH-1:0];
        ob.write_data    = ib.byte_in;
        sh_index++;
        if (sh_index >= sh_size) begin
          sh_phase = PH_HEADER;
          sh_count = 0;
          boundary = 1'b1;
        end
      end
      default: sh_phase = PH_FAILED;
    endcase
    if (ib.end_of_stream) begin
      ob.load_status = boundary ? ST_OK : ST_FAILED;
      clear_section_state();
    end
    return ob;
  endfunction

  // Receiver: checks each result beat and draws its own stall pattern.
  always @(posedge clk) begin : result_side
    out_beat_t want;
    logic      taken;
    taken = !rst && result_valid === 1'b1 && result_stall === 1'b0;
    if (taken) begin
      if (predicted_results.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (result_beat.write_valid !== want.write_valid) begin
          $error("write_valid: expected %0d, got %0d", want.write_valid,
                 result_beat.write_valid);
          mismatches++;
        end
        if (result_beat.target_store !== want.target_store) begin
          $error("target_store: expected %0d, got %0d", want.target_store,
                 result_beat.target_store);
          mismatches++;
        end
        if (result_beat.write_address !== want.write_address) begin
          $error("write_address: expected %h, got %h", want.write_address,
                 result_beat.write_address);
          mismatches++;
        end
        if (result_beat.write_data !== want.write_data) begin
          $error("write_data: expected %h, got %h", want.write_data,
                 result_beat.write_data);
          mismatches++;
        end
        if (result_beat.load_status !== want.load_status) begin
          $error("load_status: expected %0d, got %0d", want.load_status,
                 result_beat.load_status);
          mismatches++;
        end
      end
      rx_wait = no_gaps ? 0 : $urandom_range(0, 6);
    end
    if (hold_req) begin
      rx_wait  = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rx_wait > 0) begin
      result_stall <= 1'b1;
      rx_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: a run of cycles with no beat on any channel means a hang.
  always @(posedge clk) begin
    if ((byte_valid === 1'b1 && byte_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one byte after a random gap; valid stays up once the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_beat_t beat;
    int       gap;
    beat.byte_in       = b;
    beat.end_of_stream = eos;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat  <= beat;
    do @(posedge clk); while (byte_stall !== 1'b0);
    predicted_results.push_back(deframe_byte(beat));
    bytes_sent++;
  endtask

  task automatic send_stream(input octet_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic add_header(ref octet_q_t q, input logic [23:0] tag,
                            input logic [31:0] off, input logic [31:0] sz);
    q.push_back(tag[23:16]);
    q.push_back(tag[15:8]);
    q.push_back(tag[7:0]);
    for (int i = 0; i < 4; i++) q.push_back(off[8*i +: 8]);
    for (int i = 0; i < 4; i++) q.push_back(sz[8*i +: 8]);
  endtask

  task automatic add_payload(ref octet_q_t q, input int n);
    repeat (n) q.push_back(8'($urandom));
  endtask

  // Mostly well-formed sections with random content; the rest break a rule.
  task automatic add_random_section(ref octet_q_t q);
    logic [23:0] tag;
    logic [31:0] lim;
    logic [31:0] off;
    logic [31:0] sz;
    int          kind;
    int          n;
    kind = $urandom_range(0, 11);
    case ($urandom_range(0, 2))
      0: begin
        tag = TAG_KEY;
        lim = 32'(sh_key_limit);
      end
      1: begin
        tag = TAG_Z80;
        lim = 32'(sh_program_limit);
      end
      default: begin
        tag = TAG_SMP;
        lim = 32'(sh_sample_limit);
      end
    endcase
    sz = $urandom_range(0, (lim < 12) ? lim : 12);
    case ($urandom_range(0, 3))
      0: off = '0;
      1: off = lim - sz;  // section ends exactly at the limit
      default: off = $urandom_range(0, lim - sz);
    endcase
    n = sz;
    case (kind)
      0: tag = 24'($urandom);  // almost always an unknown tag
      1: off = lim - sz + 1;   // end one past the limit
      2: off = $urandom_range(lim + 1, 32'hFFFF_FFFF);
      3: sz  = $urandom | 32'hC000_0000;
      default: ;
    endcase
    if (kind <= 3) n = $urandom_range(0, 3);  // stray bytes after a bad header
    add_header(q, tag, off, sz);
    add_payload(q, n);
  endtask

  task automatic send_random_stream();
    octet_q_t q;
    int       cut;
    if ($urandom_range(0, 9) == 0) begin
      add_payload(q, $urandom_range(1, 20));  // raw noise
    end else begin
      repeat ($urandom_range(1, 3)) add_random_section(q);
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, q.size());
        q = q[0:cut-1];
      end
    end
    send_stream(q);
  endtask

  task automatic send_random_bytes(input int count);
    int goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) send_random_stream();
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_limits(input logic [3:0] k, input logic [19:0] p,
                              input logic [29:0] s);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_KEY_LIMIT;
    cfg_data  <= 30'(k);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sh_key_limit = k;
    cfg_index <= CFG_PROGRAM_LIMIT;
    cfg_data  <= 30'(p);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sh_program_limit = p;
    cfg_index <= CFG_SAMPLE_LIMIT;
    cfg_data  <= s;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sh_sample_limit = s;
    cfg_valid <= 1'b0;
  endtask

  // Limits at reset: every tag, limit edges, each failure and truncation.
  task automatic test_directed_cases();
    octet_q_t q;
    add_header(q, TAG_KEY, 0, 2);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    send_stream(q);
    q = {};
    q.push_back(8'hA5);  // stream ends inside the header
    send_stream(q);
    q = {};
    add_header(q, TAG_KEY, 11, 0);  // empty payload, offset at the limit
    send_stream(q);
    q = {};
    add_header(q, TAG_Z80, 32'h7FFFE, 2);
    add_payload(q, 2);
    send_stream(q);
    q = {};
    add_header(q, TAG_SMP, 32'h1FFF_FFFF, 1);  // highest address
    add_payload(q, 1);
    add_header(q, TAG_KEY, 12, 0);  // offset past the limit
    q.push_back(8'h3C);             // byte after the failure
    send_stream(q);
    q = {};
    add_header(q, TAG_KEY, 5, 7);  // size one past the room left
    send_stream(q);
    q = {};
    add_header(q, 24'h4B4558, 0, 1);  // one letter off a real tag
    add_payload(q, 1);
    send_stream(q);
    q = {};
    add_header(q, TAG_SMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_stream(q);
    q = {};
    add_header(q, TAG_Z80, 0, 4);  // payload cut short
    add_payload(q, 2);
    send_stream(q);
  endtask

  task automatic test_limit_settings();
    apply_limits(4'd0, 20'd0, 30'd0);
    send_random_bytes(180);
    apply_limits(4'd1, 20'd16, 30'd40);
    send_random_bytes(180);
    apply_limits(4'd5, 20'd1000, 30'd70000);
    send_random_bytes(180);
    apply_limits(4'd11, 20'd524288, 30'd536870912);
    send_random_bytes(180);
    apply_limits(4'd7, 20'd3, 30'd536870912);
    send_random_bytes(180);
  endtask

  // Sample limit above the address range lets offset + index wrap.
  task automatic test_address_wrap();
    octet_q_t q;
    apply_limits(4'd11, 20'd524288, 30'h3FFF_FFFF);
    add_header(q, TAG_SMP, 32'h1FFF_FFFE, 4);
    add_payload(q, 4);
    send_stream(q);
    send_random_bytes(150);
  endtask

  task automatic test_back_to_back();
    apply_limits(4'd11, 20'd2048, 30'd4096);
    no_gaps = 1'b1;
    send_random_bytes(150);
    no_gaps = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_holdoff();
    wait_idle();
    hold_req = 1'b1;
    no_gaps = 1'b1;
    send_random_bytes(40);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    byte_valid   <= 1'b0;
    byte_beat    <= '0;
    result_stall <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_KEY_LIMIT;
    cfg_data     <= '0;
    sh_key_limit     = KEY_LIMIT_RESET;
    sh_program_limit = PROGRAM_LIMIT_RESET;
    sh_sample_limit  = SAMPLE_LIMIT_RESET;
    clear_section_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_limit_settings();
    test_address_wrap();
    test_back_to_back();
    test_output_holdoff();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
